/* rtl/median_five_deadzone_filter_defines.svh */
// ----------------------------------------------------------------------------
// median_five_deadzone_filter_defines.svh
// Assertion macros shared by the median/deadzone filter RTL.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FIVE_DEADZONE_FILTER_DEFINES_SVH
`define MEDIAN_FIVE_DEADZONE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define MFDZ_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// checked at every edge, reset included
`define MFDZ_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`else

`define MFDZ_ASSERT(name, clk, rst_n, prop)
`define MFDZ_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

/* rtl/mfdz_pkg.sv */
// ----------------------------------------------------------------------------
// mfdz_pkg
// Types and constants of the median-of-five deadzone filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfdz_pkg;

	localparam int ANGLE_W     = 16;
	localparam int THR_W       = 15;
	localparam int LANE_DEPTH  = 4;
	localparam int WIN         = LANE_DEPTH + 1;
	localparam int RANK_W      = $clog2(WIN);
	localparam int CFG_INDEX_W = 1;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [THR_W-1:0]          thr_t;
	typedef logic [RANK_W-1:0]         rank_t;

	// middle of five sorted entries
	localparam rank_t MED_RANK = rank_t'(WIN / 2);

	// 0.15 deg in Q2.13 rad, truncated
	localparam thr_t DEADZONE_RESET = thr_t'(21);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PITCH_DEADZONE = 1'b0,
		CFG_ROLL_DEADZONE  = 1'b1
	} cfg_index_t;

endpackage

`default_nettype wire

/* rtl/mfdz_lane.sv */
// ----------------------------------------------------------------------------
// mfdz_lane
// One angle lane: four-sample history, median of five, symmetric deadzone.
// ----------------------------------------------------------------------------
`default_nettype none

module mfdz_lane (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire mfdz_pkg::angle_t sample,
	input  wire mfdz_pkg::thr_t  thr,
	output mfdz_pkg::angle_t     result
);
	import mfdz_pkg::*;

	angle_t            history_q [LANE_DEPTH];
	angle_t            win       [WIN];
	rank_t             rank      [WIN];
	angle_t            med;
	logic signed [ANGLE_W:0] med_ext;
	logic signed [ANGLE_W:0] thr_ext;
	logic signed [ANGLE_W:0] dz;

	// oldest sample at index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_DEPTH; i++) begin
				history_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < LANE_DEPTH - 1; i++) begin
				history_q[i] <= history_q[i + 1];
			end
			history_q[LANE_DEPTH - 1] <= sample;
		end
	end

	always_comb begin
		for (int i = 0; i < LANE_DEPTH; i++) begin
			win[i] = history_q[i];
		end
		win[WIN - 1] = sample;
	end

	// rank by parallel compare, ties broken by position, so ranks are unique
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WIN; j++) begin
				if (j < i) begin
					if (win[j] <= win[i]) begin
						rank[i] = rank[i] + rank_t'(1);
					end
				end else if (j > i) begin
					if (win[j] < win[i]) begin
						rank[i] = rank[i] + rank_t'(1);
					end
				end
			end
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < WIN; i++) begin
			if (rank[i] == MED_RANK) begin
				med = win[i];
			end
		end
	end

	assign med_ext = {med[ANGLE_W-1], med};
	assign thr_ext = $signed({2'b00, thr});

	always_comb begin
		priority if (med_ext > thr_ext) begin
			dz = med_ext - thr_ext;
		end else if (med_ext < -thr_ext) begin
			dz = med_ext + thr_ext;
		end else begin
			dz = '0;
		end
	end

	// magnitude only shrinks, so the low bits carry the full result
	assign result = dz[ANGLE_W-1:0];

endmodule

`default_nettype wire

/* rtl/median_five_deadzone_filter.sv */
// ----------------------------------------------------------------------------
// median_five_deadzone_filter
// Path: input register, one pass of compare/select/deadzone logic, then the
// result register. Throughput: one sample pair per cycle while the output
// is not stalled. The input register also absorbs one transaction while a
// result is stalled.
// Reset: asynchronous, clears both histories to zero, empties both stages and
// sets both deadzones to 21 LSB.
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_five_deadzone_filter_defines.svh"

module median_five_deadzone_filter (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_write,
	input  wire mfdz_pkg::cfg_index_t cfg_index,
	input  wire mfdz_pkg::thr_t    cfg_data,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire mfdz_pkg::angle_t  pitch_sample,
	input  wire mfdz_pkg::angle_t  roll_sample,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output mfdz_pkg::angle_t       pitch_filtered,
	output mfdz_pkg::angle_t       roll_filtered
);
	import mfdz_pkg::*;

	thr_t   pitch_deadzone_q;
	thr_t   roll_deadzone_q;

	logic   valid_s1;
	angle_t pitch_s1;
	angle_t roll_s1;

	logic   out_valid_q;
	angle_t pitch_filtered_q;
	angle_t roll_filtered_q;

	logic   advance;
	logic   accept;
	angle_t pitch_result;
	angle_t roll_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_deadzone_q <= DEADZONE_RESET;
			roll_deadzone_q  <= DEADZONE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PITCH_DEADZONE: pitch_deadzone_q <= cfg_data;
				CFG_ROLL_DEADZONE:  roll_deadzone_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept || advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pitch_s1 <= pitch_sample;
			roll_s1  <= roll_sample;
		end
	end

	mfdz_lane u_pitch_lane (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sample  (pitch_s1),
		.thr     (pitch_deadzone_q),
		.result  (pitch_result)
	);

	mfdz_lane u_roll_lane (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sample  (roll_s1),
		.thr     (roll_deadzone_q),
		.result  (roll_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pitch_filtered_q <= pitch_result;
			roll_filtered_q  <= roll_result;
		end
	end

	assign out_valid      = out_valid_q;
	assign pitch_filtered = pitch_filtered_q;
	assign roll_filtered  = roll_filtered_q;

	`MFDZ_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !valid_s1 && !out_valid_q)
	`MFDZ_ASSERT(a_stall_needs_full_out, clk, arst_n, in_stall |-> valid_s1 && out_valid_q)
	`MFDZ_ASSERT(a_advance_fills_out, clk, arst_n, advance |=> out_valid_q)
	`MFDZ_ASSERT(a_out_from_stage1, clk, arst_n, $rose(out_valid_q) |-> $past(advance))
	`MFDZ_ASSERT(a_accept_fills_s1, clk, arst_n, accept |=> valid_s1)

endmodule

`default_nettype wire
